/* design/sha256_pkg.sv */
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_PAD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       take_byte;
        logic       pad_byte;
        logic       start_block;
        logic       round_step;
        logic       add_hash;
        logic       init_hash;
        logic [2:0] emit_sel;
    } cmd_t;

    typedef struct packed {
        logic       block_full;
        logic       last_round;
        logic       len_done;
        logic [6:0] fill;
    } status_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [6:0] BLOCK_BYTES = 7'd64;
    localparam logic [6:0] LEN_START   = 7'd56;
    localparam logic [7:0] PAD_MARK    = 8'h80;

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        ror = (v >> n) | (v << (32 - n));
    endfunction

endpackage

/* design/sha256_ctrl.sv */
module sha256_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_present,
    input  logic                in_end,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_last,
    input  sha256_pkg::status_t status,
    output sha256_pkg::cmd_t    cmd
);

    sha256_pkg::state_t state_reg, state_next;
    logic               fin_reg, fin_next;
    logic [2:0]         idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha256_pkg::ST_IDLE;
            fin_reg   <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            idx_reg   <= idx_next;
        end
    end

    // fin_reg: closing sequence; padding in progress
    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        idx_next   = idx_reg;
        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_present && status.fill == sha256_pkg::BLOCK_BYTES - 7'd1)
                    begin
                        state_next = sha256_pkg::ST_ROUND;
                        fin_next   = in_end;
                    end
                    else if (in_end)
                    begin
                        state_next = sha256_pkg::ST_PAD;
                        fin_next   = 1'b1;
                    end
                end
            end
            sha256_pkg::ST_PAD:
            begin
                if (status.block_full)
                    state_next = sha256_pkg::ST_ROUND;
            end
            sha256_pkg::ST_ROUND:
            begin
                if (status.last_round)
                    state_next = sha256_pkg::ST_FINAL;
            end
            sha256_pkg::ST_FINAL:
            begin
                if (!fin_reg)
                    state_next = sha256_pkg::ST_IDLE;
                else if (status.len_done)
                    state_next = sha256_pkg::ST_EMIT;
                else
                    state_next = sha256_pkg::ST_PAD;
                idx_next = 3'd0;
            end
            sha256_pkg::ST_EMIT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        state_next = sha256_pkg::ST_IDLE;
                        fin_next   = 1'b0;
                    end
                end
            end
            default:
                state_next = sha256_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        out_last  = 1'b0;
        cmd.emit_sel = idx_reg;
        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.take_byte = in_valid && in_present;
                cmd.pad_byte  = in_valid && in_end
                                && !(in_present && status.fill == sha256_pkg::BLOCK_BYTES - 7'd1);
                cmd.start_block = in_valid && in_present
                                  && status.fill == sha256_pkg::BLOCK_BYTES - 7'd1;
            end
            sha256_pkg::ST_PAD:
            begin
                cmd.pad_byte    = !status.block_full;
                cmd.start_block = status.block_full;
            end
            sha256_pkg::ST_ROUND:
                cmd.round_step = 1'b1;
            sha256_pkg::ST_FINAL:
                cmd.add_hash = 1'b1;
            sha256_pkg::ST_EMIT:
            begin
                out_valid    = 1'b1;
                out_last     = idx_reg == 3'd7;
                cmd.init_hash = out_ready && idx_reg == 3'd7;
            end
            default:
                cmd = '0;
        endcase
    end

endmodule

/* design/sha256_dp.sv */
module sha256_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          in_byte,
    input  sha256_pkg::cmd_t    cmd,
    output sha256_pkg::status_t status,
    output logic [31:0]         digest
);

    logic [31:0] hash_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [63:0] bits_reg;
    logic [6:0]  fill_reg;
    logic [5:0]  rnd_reg;
    logic        pend_reg;      // padding mark already placed
    logic        full_reg;
    logic        len_ok_reg;
    logic        done_reg;

    logic [31:0] w_cur, w_new, s0, s1, t1, t2;
    logic [7:0]  pad_val;
    logic [5:0]  fpos;
    logic [63:0] len_word;
    logic [2:0]  lsel;

    assign fpos     = fill_reg[5:0];
    assign len_word = bits_reg;
    assign lsel     = 3'd7 - fpos[2:0];
    assign pad_val  = !pend_reg ? sha256_pkg::PAD_MARK :
                      (fill_reg >= sha256_pkg::LEN_START && len_ok_reg)
                      ? len_word[lsel*8 +: 8] : 8'h00;

    assign s0 = sha256_pkg::ror(w_reg[1], 7) ^ sha256_pkg::ror(w_reg[1], 18)
                ^ (w_reg[1] >> 3);
    assign s1 = sha256_pkg::ror(w_reg[14], 17) ^ sha256_pkg::ror(w_reg[14], 19)
                ^ (w_reg[14] >> 10);
    assign w_new = w_reg[0] + s0 + w_reg[9] + s1;
    assign w_cur = (rnd_reg < 6'd16) ? w_reg[0] : w_new;

    assign t1 = v_reg[7]
              + (sha256_pkg::ror(v_reg[4], 6) ^ sha256_pkg::ror(v_reg[4], 11)
                 ^ sha256_pkg::ror(v_reg[4], 25))
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + sha256_pkg::ROUND_K[rnd_reg] + w_cur;
    assign t2 = (sha256_pkg::ror(v_reg[0], 2) ^ sha256_pkg::ror(v_reg[0], 13)
                 ^ sha256_pkg::ror(v_reg[0], 22))
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    assign status.block_full = full_reg;
    assign status.last_round = rnd_reg == 6'd63;
    assign status.len_done   = done_reg;
    assign status.fill       = fill_reg;
    assign digest            = hash_reg[cmd.emit_sel];

    always_ff @(posedge clk)
    begin
        if (cmd.take_byte || cmd.pad_byte)
            w_reg[fpos[5:2]][{~fpos[1:0], 3'b000} +: 8] <= cmd.take_byte ? in_byte : pad_val;
        else if (cmd.round_step)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_cur;
        end
        if (cmd.start_block)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= hash_reg[i];
        end
        else if (cmd.round_step)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // w_reg[0] holds schedule word for rounds 0-15; later rounds use w_new from i-16, i-15, i-7, i-2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= sha256_pkg::START_HASH[i];
            bits_reg   <= '0;
            fill_reg   <= '0;
            rnd_reg    <= '0;
            pend_reg   <= 1'b0;
            full_reg   <= 1'b0;
            len_ok_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.take_byte)
            begin
                bits_reg <= bits_reg + 64'd8;
                fill_reg <= (fill_reg == sha256_pkg::BLOCK_BYTES - 7'd1) ? 7'd0
                            : fill_reg + 7'd1;
            end
            else if (cmd.pad_byte)
            begin
                pend_reg <= 1'b1;
                full_reg <= fill_reg == sha256_pkg::BLOCK_BYTES - 7'd1;
                fill_reg <= (fill_reg == sha256_pkg::BLOCK_BYTES - 7'd1) ? 7'd0
                            : fill_reg + 7'd1;
                if ((!pend_reg && fill_reg < sha256_pkg::LEN_START)
                    || (pend_reg && fill_reg == 7'd0))
                    len_ok_reg <= 1'b1;
                if (len_ok_reg && fill_reg == sha256_pkg::BLOCK_BYTES - 7'd1)
                    done_reg <= 1'b1;
            end
            if (cmd.start_block)
            begin
                rnd_reg  <= '0;
                full_reg <= 1'b0;
            end
            else if (cmd.round_step)
                rnd_reg <= rnd_reg + 6'd1;
            if (cmd.add_hash)
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= hash_reg[i] + v_reg[i];
            if (cmd.init_hash)
            begin
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= sha256_pkg::START_HASH[i];
                bits_reg   <= '0;
                fill_reg   <= '0;
                pend_reg   <= 1'b0;
                len_ok_reg <= 1'b0;
                done_reg   <= 1'b0;
            end
        end
    end

endmodule

/* design/sha256_byte_stream_hasher.sv */
// One byte item per cycle while a block fills; a full block stalls input for
// 64 compression rounds (one round per cycle) and the hash-add step.
// End of message: padding bytes one per cycle up to 64 per block, one or
// two compressions, then eight digest items, one per cycle when taken.
// Reset (rst_n low, asynchronous) loads the initial hash values and clears
// the bit count, fill count and controller state.
module sha256_byte_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);

    sha256_pkg::cmd_t    cmd;
    sha256_pkg::status_t status;

    sha256_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_present (s_axis_tuser),
        .in_end     (s_axis_tlast),
        .in_ready   (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_last   (m_axis_tlast),
        .status     (status),
        .cmd        (cmd)
    );

    sha256_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_byte (s_axis_tdata),
        .cmd     (cmd),
        .status  (status),
        .digest  (m_axis_tdata)
    );

    assign m_axis_tuser = cmd.emit_sel;

endmodule
